/* rtl/core/afr_pkg.sv */
// afr_pkg: shared types and constants of the addressed frame receiver
// used by afr_parser, afr_seq and the top level; depends on nothing

package afr_pkg;

   // frame bytes with a fixed meaning
   localparam logic [7:0] SYNC_BYTE   = 8'h55;
   localparam logic [7:0] ZERO_BYTE   = 8'h00;
   localparam logic [7:0] CHK_BUMP_A  = 8'h56;
   localparam logic [7:0] CHK_BUMP_B  = 8'h45;
   localparam logic [7:0] CHK_BUMP_C  = 8'h34;
   localparam logic [7:0] DEVICE_ID_RESET = 8'hAA;

   // command codes
   localparam logic [7:0] CMD_OVF_TEXT = 8'h01;
   localparam logic [7:0] CMD_TEXT     = 8'h02;
   localparam logic [7:0] CMD_ZERO     = 8'h03;
   localparam logic [7:0] CMD_TEST_ON  = 8'h04;
   localparam logic [7:0] CMD_TEST_OFF = 8'h05;

   // acknowledgment codes
   localparam logic [7:0] ACK_OK       = 8'h01;
   localparam logic [7:0] ACK_BAD_SUM  = 8'h02;
   localparam logic [7:0] ACK_UNKNOWN  = 8'h03;
   localparam logic [7:0] ACK_OVERFLOW = 8'h04;

   // display actions
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_DASHES = 3'd6;

   // position of the checksum byte in the acknowledgment
   localparam logic [2:0] ACK_LAST_IDX = 3'd4;

   // parser frame states
   typedef enum logic [4:0] {
      P_IDLE = 5'b00001,
      P_HAND = 5'b00010,
      P_CMD  = 5'b00100,
      P_DATA = 5'b01000,
      P_CHK  = 5'b10000
   } frame_state_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CMD  = 4'b0010,
      S_TEXT = 4'b0100,
      S_ACK  = 4'b1000
   } seq_state_type;

   // how a frame ended
   typedef enum logic [1:0] {
      JOB_GOOD     = 2'd0,
      JOB_BAD      = 2'd1,
      JOB_OVERFLOW = 2'd2
   } job_kind_type;

   // frame end request from parser to sequencer
   typedef struct packed {
      logic         valid;
      job_kind_type kind;
   } job_type;

endpackage

/* rtl/core/afr_buf_mem.sv */
// afr_buf_mem: frame buffer, one write port and one registered read port
// depends on nothing

module afr_buf_mem #(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
   output logic [7:0]                      rd_data
);

   logic [7:0] mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/afr_parser.sv */
// afr_parser: frame state, byte count and running check; writes the buffer
// depends on afr_pkg; drives afr_buf_mem writes and hands frame ends to afr_seq

module afr_parser #(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        device_id,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data,
   input  logic                              seq_busy,
   output logic                              mem_wr_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0]   mem_wr_addr,
   output logic [7:0]                        mem_wr_data,
   output afr_pkg::job_type                  job,
   output logic [$clog2(BUFFER_DEPTH+1)-1:0] job_count
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   afr_pkg::frame_state_type state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [7:0]               check_ff, check_in;
   afr_pkg::job_type         job_ff, job_in;
   logic [CW-1:0]            job_count_ff, job_count_in;
   logic                     accept;
   logic [7:0]               check_fix;
   logic                     sum_good;

   // one transaction at a time, held off while a run drains
   assign req_ready = !seq_busy && !job_ff.valid;
   assign accept    = req_valid && req_ready;

   // checksum compare with the bump on three check values
   always_comb begin
      check_fix = check_ff;
      if (check_ff == afr_pkg::CHK_BUMP_A || check_ff == afr_pkg::CHK_BUMP_B ||
          check_ff == afr_pkg::CHK_BUMP_C) begin
         check_fix = check_ff + 8'd1;
      end
   end
   assign sum_good = (check_fix + req_data) == 8'h00;

   // frame parsing
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      check_in     = check_ff;
      job_in       = '{valid: 1'b0, kind: afr_pkg::JOB_BAD};
      job_count_in = job_count_ff;
      mem_wr_en    = 1'b0;
      if (accept) begin
         unique case (state_ff)
            afr_pkg::P_IDLE: begin
               if (req_data == device_id) begin
                  state_in = afr_pkg::P_HAND;
                  check_in = check_ff ^ req_data;
               end else begin
                  state_in = afr_pkg::P_IDLE;
                  count_in = '0;
                  check_in = 8'h00;
               end
            end
            afr_pkg::P_HAND: begin
               if (req_data == afr_pkg::SYNC_BYTE) begin
                  state_in = afr_pkg::P_CMD;
                  check_in = check_ff ^ req_data;
               end else begin
                  state_in = afr_pkg::P_IDLE;
                  count_in = '0;
                  check_in = 8'h00;
               end
            end
            afr_pkg::P_CMD: begin
               state_in  = afr_pkg::P_DATA;
               check_in  = check_ff ^ req_data;
               mem_wr_en = 1'b1;
               count_in  = count_ff + CW'(1);
            end
            afr_pkg::P_DATA: begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + CW'(1);
               check_in  = check_ff ^ req_data;
               if (count_ff == CW'(BUFFER_DEPTH - 1)) begin
                  // buffer full: drop the frame, report overflow
                  state_in = afr_pkg::P_IDLE;
                  count_in = '0;
                  check_in = 8'h00;
                  job_in   = '{valid: 1'b1, kind: afr_pkg::JOB_OVERFLOW};
               end else if (req_data == afr_pkg::ZERO_BYTE) begin
                  state_in = afr_pkg::P_CHK;
               end
            end
            afr_pkg::P_CHK: begin
               job_in.valid = 1'b1;
               job_in.kind  = sum_good ? afr_pkg::JOB_GOOD : afr_pkg::JOB_BAD;
               job_count_in = count_ff;
               state_in     = afr_pkg::P_IDLE;
               count_in     = '0;
               check_in     = 8'h00;
            end
            default: begin
               state_in = afr_pkg::P_IDLE;
               count_in = '0;
               check_in = 8'h00;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= afr_pkg::P_IDLE;
         count_ff <= '0;
         check_ff <= 8'h00;
         job_ff   <= '{valid: 1'b0, kind: afr_pkg::JOB_BAD};
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         check_ff <= check_in;
         job_ff   <= job_in;
      end
   end

   // frame length handed with the job
   always_ff @(posedge clock) begin
      job_count_ff <= job_count_in;
   end

   assign mem_wr_addr = count_ff[AW-1:0];
   assign mem_wr_data = req_data;
   assign job         = job_ff;
   assign job_count   = job_count_ff;

endmodule

/* rtl/core/afr_seq.sv */
// afr_seq: runs the command of a finished frame, streams text and acknowledgment
// depends on afr_pkg; reads afr_buf_mem and owns the result output register

module afr_seq #(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        device_id,
   input  afr_pkg::job_type                  job,
   input  logic [$clog2(BUFFER_DEPTH+1)-1:0] job_count,
   output logic                              busy,
   output logic                              mem_rd_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0]   mem_rd_addr,
   input  logic [7:0]                        mem_rd_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic                              out_kind,
   output logic [7:0]                        out_byte,
   output logic [2:0]                        out_action,
   output logic                              out_last
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   afr_pkg::seq_state_type state_ff, state_in;
   logic [7:0]    code_ff, code_in;
   logic [2:0]    action_ff, action_in;
   logic [2:0]    ack_idx_ff, ack_idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] text_addr_ff, text_addr_in;
   logic [AW-1:0] text_last_ff, text_last_in;
   logic          text_done_ff, text_done_in;
   logic          rdv_ff, rdv_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_kind_ff, out_kind_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic [2:0]    out_action_ff, out_action_in;
   logic          out_last_ff, out_last_in;
   logic          out_free;
   logic          load_text;
   logic          load_ack;
   logic          issue;
   logic          start_read;
   logic [7:0]    ack_byte;

   assign out_free   = !out_valid_ff || out_ready;
   assign load_text  = rdv_ff && out_free;
   assign load_ack   = (state_ff == afr_pkg::S_ACK) && out_free;
   assign issue      = (state_ff == afr_pkg::S_TEXT) && !text_done_ff &&
                       (!rdv_ff || load_text);
   assign start_read = (state_ff == afr_pkg::S_IDLE) && job.valid &&
                       (job.kind == afr_pkg::JOB_GOOD);

   // buffer read: command byte first, then text bytes one per cycle while the output is not stalled
   assign mem_rd_en   = issue || start_read;
   assign mem_rd_addr = issue ? text_addr_ff : '0;

   // acknowledgment byte selection
   always_comb begin
      case (ack_idx_ff)
         3'd0:    ack_byte = device_id;
         3'd1:    ack_byte = afr_pkg::SYNC_BYTE;
         3'd2:    ack_byte = code_ff;
         3'd3:    ack_byte = afr_pkg::ZERO_BYTE;
         3'd4:    ack_byte = 8'h00 - (device_id ^ afr_pkg::SYNC_BYTE ^ code_ff);
         default: ack_byte = afr_pkg::ZERO_BYTE;
      endcase
   end

   // run sequencing
   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      action_in    = action_ff;
      ack_idx_in   = ack_idx_ff;
      count_in     = count_ff;
      text_addr_in = text_addr_ff;
      text_last_in = text_last_ff;
      text_done_in = text_done_ff;
      unique case (state_ff)
         afr_pkg::S_IDLE: begin
            ack_idx_in = 3'd0;
            if (job.valid) begin
               count_in = job_count;
               unique case (job.kind)
                  afr_pkg::JOB_GOOD: begin
                     state_in = afr_pkg::S_CMD;
                  end
                  afr_pkg::JOB_OVERFLOW: begin
                     state_in  = afr_pkg::S_ACK;
                     code_in   = afr_pkg::ACK_OVERFLOW;
                     action_in = afr_pkg::ACT_NONE;
                  end
                  default: begin
                     state_in  = afr_pkg::S_ACK;
                     code_in   = afr_pkg::ACK_BAD_SUM;
                     action_in = afr_pkg::ACT_DASHES;
                  end
               endcase
            end
         end
         afr_pkg::S_CMD: begin
            // command byte is on the read port now
            state_in = afr_pkg::S_ACK;
            unique case (mem_rd_data) inside
               afr_pkg::CMD_OVF_TEXT, afr_pkg::CMD_ZERO, afr_pkg::CMD_TEST_ON,
               afr_pkg::CMD_TEST_OFF: begin
                  code_in   = afr_pkg::ACK_OK;
                  action_in = mem_rd_data[2:0];
               end
               afr_pkg::CMD_TEXT: begin
                  code_in      = afr_pkg::ACK_OK;
                  action_in    = mem_rd_data[2:0];
                  text_addr_in = AW'(1);
                  text_last_in = AW'(count_ff - CW'(2));
                  text_done_in = 1'b0;
                  if (count_ff > CW'(2)) begin
                     state_in = afr_pkg::S_TEXT;
                  end
               end
               default: begin
                  code_in   = afr_pkg::ACK_UNKNOWN;
                  action_in = afr_pkg::ACT_NONE;
               end
            endcase
         end
         afr_pkg::S_TEXT: begin
            if (issue) begin
               text_addr_in = text_addr_ff + AW'(1);
               if (text_addr_ff == text_last_ff) begin
                  text_done_in = 1'b1;
               end
            end
            if (text_done_ff && !rdv_ff) begin
               state_in = afr_pkg::S_ACK;
            end
         end
         afr_pkg::S_ACK: begin
            if (load_ack) begin
               ack_idx_in = ack_idx_ff + 3'd1;
               if (ack_idx_ff == afr_pkg::ACK_LAST_IDX) begin
                  state_in = afr_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = afr_pkg::S_IDLE;
         end
      endcase
   end

   // read data stage: set by a text read, cleared when moved to the output
   always_comb begin
      rdv_in = rdv_ff;
      if (issue) begin
         rdv_in = 1'b1;
      end else if (load_text) begin
         rdv_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_byte_in   = out_byte_ff;
      out_action_in = out_action_ff;
      out_last_in   = out_last_ff;
      if (load_text) begin
         out_valid_in  = 1'b1;
         out_kind_in   = 1'b1;
         out_byte_in   = mem_rd_data;
         out_action_in = action_ff;
         out_last_in   = 1'b0;
      end else if (load_ack) begin
         out_valid_in  = 1'b1;
         out_kind_in   = 1'b0;
         out_byte_in   = ack_byte;
         out_action_in = action_ff;
         out_last_in   = (ack_idx_ff == afr_pkg::ACK_LAST_IDX);
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afr_pkg::S_IDLE;
         ack_idx_ff   <= 3'd0;
         text_done_ff <= 1'b1;
         rdv_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ack_idx_ff   <= ack_idx_in;
         text_done_ff <= text_done_in;
         rdv_ff       <= rdv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      action_ff     <= action_in;
      count_ff      <= count_in;
      text_addr_ff  <= text_addr_in;
      text_last_ff  <= text_last_in;
      out_kind_ff   <= out_kind_in;
      out_byte_ff   <= out_byte_in;
      out_action_ff <= out_action_in;
      out_last_ff   <= out_last_in;
   end

   assign busy       = (state_ff != afr_pkg::S_IDLE);
   assign out_valid  = out_valid_ff;
   assign out_kind   = out_kind_ff;
   assign out_byte   = out_byte_ff;
   assign out_action = out_action_ff;
   assign out_last   = out_last_ff;

endmodule

/* rtl/core/addressed_frame_receiver_with_ack.sv */
// frame end: the closing byte is registered as a job; a good checksum then reads the
//   command byte, and text bytes pass the read data stage before the acknowledgment
// throughput: one byte per cycle while no run is pending; a run then streams one result
//   per cycle while the output is not stalled; input waits until its last is loaded
// reset: synchronous, active high; clears frame state, count, check, run and output
//   valid, and sets device_id to 0xAA; the frame buffer is not cleared

// addressed_frame_receiver_with_ack: top level, device id register and wiring
// depends on afr_pkg, afr_buf_mem, afr_parser and afr_seq

module addressed_frame_receiver_with_ack #(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // received bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] display_action, rest zero
   output logic        rsp_tuser,   // [0] out_kind
   output logic        rsp_tlast,   // last_of_run
   // device id register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   logic [7:0]       device_id_ff, device_id_in;
   logic             seq_busy;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [7:0]       mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [7:0]       mem_rd_data;
   afr_pkg::job_type job;
   logic [CW-1:0]    job_count;
   logic [7:0]       out_byte;
   logic [2:0]       out_action;

   // device id register, written by a csr transaction
   assign csr_ready    = 1'b1;
   assign device_id_in = (csr_valid && csr_ready) ? csr_wdata : device_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= afr_pkg::DEVICE_ID_RESET;
      end else begin
         device_id_ff <= device_id_in;
      end
   end

   // frame buffer
   afr_buf_mem #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // frame parser
   afr_parser #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .device_id   (device_id_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_data    (req_tdata),
      .seq_busy    (seq_busy),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .job         (job),
      .job_count   (job_count)
   );

   // command and acknowledgment sequencer
   afr_seq #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .device_id   (device_id_ff),
      .job         (job),
      .job_count   (job_count),
      .busy        (seq_busy),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (rsp_tuser),
      .out_byte    (out_byte),
      .out_action  (out_action),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, out_action, out_byte};

endmodule

/* rtl/core/afr_checker.sv */
// afr_checker: port-level checks of the frame receiver, bound to the top level
// depends on addressed_frame_receiver_with_ack

module afr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a run always ends on an acknowledgment byte
   a_last_is_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser)
      else $error("run ended on a text byte");

   // the zero terminator is never shown as text
   a_text_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[7:0] != 8'h00)
      else $error("zero text byte");

   // display action stays in its range
   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:8] != 3'd7)
      else $error("bad display action");

   // nothing valid right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind addressed_frame_receiver_with_ack afr_checker u_afr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
